// File: design/rbdv_pkg.sv
// Package for the RTC BCD date checker: calendar constants, weekday
// offsets and BCD helper functions.
// No dependencies.
package rbdv_pkg;

  localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;
  localparam logic [6:0] CENTURY_MAX   = 7'd99;
  localparam logic [6:0] YEAR_MAX      = 7'd99;
  localparam logic [3:0] MONTH_MAX     = 4'd12;
  localparam logic [4:0] DAY_MAX       = 5'd31;
  localparam logic [4:0] HOUR_MAX      = 5'd23;
  localparam logic [5:0] MINUTE_MAX    = 6'd59;
  localparam logic [5:0] SECOND_MAX    = 6'd59;
  localparam logic [3:0] MONTH_FEB     = 4'd2;
  localparam logic [3:0] MONTH_MAR     = 4'd3;
  localparam logic [3:0] WEEK_DAYS     = 4'd7;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

  // Both nibbles must be decimal digits
  function automatic logic bcd_ok(input logic [7:0] b);
    bcd_ok = (b[3:0] <= BCD_DIGIT_MAX) && (b[7:4] <= BCD_DIGIT_MAX);
  endfunction

  // hi*10 + lo, built from shifts
  function automatic logic [6:0] bcd_to_bin(input logic [7:0] b);
    bcd_to_bin = {b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {3'b000, b[3:0]};
  endfunction

  // Days in month, February from the leap flag; zero for a month code out of range
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      MONTH_FEB:                                  d = leap ? FEB_LEAP_DAYS : 5'd28;
      default:                                    d = 5'd0;
    endcase
    days_in_month = d;
  endfunction

  // Sakamoto month offsets, indexed by binary month 1..12
  function automatic logic [2:0] sak_offset(input logic [3:0] m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    sak_offset = o;
  endfunction

endpackage

// File: design/rtc_bcd_date_validator_top.sv
// RTC BCD date checker: input register, single-pass decode/check/weekday
// logic, result register. Depends on rbdv_pkg.
// A reading passes through the input register, then the result register.
// Throughput: one reading per cycle; ready drops only while both register
// stages are full and out_ready is low.
// Reset (rst, synchronous, active high) empties both register stages;
// payload registers are not reset.
module rtc_bcd_date_validator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        rtc_present,
  input  logic [7:0]  daylight_in,
  input  logic [7:0]  century_bcd,
  input  logic [7:0]  year_bcd,
  input  logic [7:0]  month_bcd,
  input  logic [7:0]  day_bcd,
  input  logic [7:0]  hour_bcd,
  input  logic [7:0]  minute_bcd,
  input  logic [7:0]  second_bcd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        date_valid,
  output logic [13:0] year_value,
  output logic [3:0]  month_value,
  output logic [4:0]  day_value,
  output logic [4:0]  hour_value,
  output logic [5:0]  minute_value,
  output logic [5:0]  second_value,
  output logic [2:0]  weekday_value,
  output logic        daylight_out
);
  import rbdv_pkg::*;

  // input stage
  logic       in_full;
  logic       rtc_present_q;
  logic [7:0] daylight_q, century_q, year_q, month_q, day_q;
  logic [7:0] hour_q, minute_q, second_q;

  logic out_adv;
  logic in_adv;

  // decode / check
  logic [6:0]  cen_bin, yl_bin, mo_bin7, dy_bin7, hr_bin7, mi_bin7, se_bin7;
  logic [3:0]  mo_bin;
  logic [4:0]  dy_bin, hr_bin;
  logic [5:0]  mi_bin, se_bin;
  logic [13:0] full_year;
  logic        digits_ok, ranges_ok, leap, ok;
  logic [4:0]  mlen;

  // weekday
  logic [6:0]  cen_adj, yl_adj;
  logic [9:0]  wd_sum;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [3:0]  wd_mod;
  logic [2:0]  weekday_next;

  assign out_adv  = !out_valid || out_ready;
  assign in_adv   = in_full && out_adv;
  assign in_ready = !in_full || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rtc_present_q <= rtc_present;
      daylight_q    <= daylight_in;
      century_q     <= century_bcd;
      year_q        <= year_bcd;
      month_q       <= month_bcd;
      day_q         <= day_bcd;
      hour_q        <= hour_bcd;
      minute_q      <= minute_bcd;
      second_q      <= second_bcd;
    end
  end

  always_comb begin
    cen_bin = bcd_to_bin(century_q);
    yl_bin  = bcd_to_bin(year_q);
    mo_bin7 = bcd_to_bin(month_q);
    dy_bin7 = bcd_to_bin(day_q);
    hr_bin7 = bcd_to_bin(hour_q);
    mi_bin7 = bcd_to_bin(minute_q);
    se_bin7 = bcd_to_bin(second_q);
    mo_bin  = mo_bin7[3:0];
    dy_bin  = dy_bin7[4:0];
    hr_bin  = hr_bin7[4:0];
    mi_bin  = mi_bin7[5:0];
    se_bin  = se_bin7[5:0];

    digits_ok = bcd_ok(century_q) && bcd_ok(year_q) && bcd_ok(month_q) &&
                bcd_ok(day_q) && bcd_ok(hour_q) && bcd_ok(minute_q) &&
                bcd_ok(second_q);
    ranges_ok = (cen_bin <= CENTURY_MAX) && (yl_bin <= YEAR_MAX) &&
                (mo_bin7 <= {3'b000, MONTH_MAX}) && (mo_bin7 != 7'd0) &&
                (dy_bin7 <= {2'b00, DAY_MAX}) && (dy_bin7 != 7'd0) &&
                (hr_bin7 <= {2'b00, HOUR_MAX}) &&
                (mi_bin7 <= {1'b0, MINUTE_MAX}) &&
                (se_bin7 <= {1'b0, SECOND_MAX});

    // century*100 = c*64 + c*32 + c*4
    full_year = {1'b0, cen_bin, 6'b0} + {2'b00, cen_bin, 5'b0} + {5'b0, cen_bin, 2'b00}
                + {7'b0, yl_bin};

    // year within century nonzero: divisible by 4; else century divisible by 4
    leap = (yl_bin != 7'd0) ? (yl_bin[1:0] == 2'b00) : (cen_bin[1:0] == 2'b00);
    mlen = days_in_month(mo_bin, leap);

    ok = rtc_present_q && (daylight_q <= 8'd1) && digits_ok && ranges_ok &&
         (full_year != 14'd0) && (dy_bin <= mlen);

    // January and February count in the previous year
    if (mo_bin >= MONTH_MAR) begin
      cen_adj = cen_bin;
      yl_adj  = yl_bin;
    end else if (yl_bin != 7'd0) begin
      cen_adj = cen_bin;
      yl_adj  = yl_bin - 7'd1;
    end else begin
      cen_adj = cen_bin - 7'd1;
      yl_adj  = YEAR_MAX;
    end

    // a = 100C + Y: a + a/4 - a/100 + a/400 == 5C + C/4 + Y + Y/4 (mod 7)
    wd_sum = {1'b0, cen_adj, 2'b00} + {3'b000, cen_adj} + {5'b0, cen_adj[6:2]}
             + {3'b000, yl_adj} + {5'b0, yl_adj[6:2]}
             + {7'b0, sak_offset(mo_bin)} + {5'b0, dy_bin};

    // 8 == 1 (mod 7): add octal digits twice, then one conditional subtract
    fold1  = {2'b00, wd_sum[2:0]} + {2'b00, wd_sum[5:3]} + {2'b00, wd_sum[8:6]}
             + {4'b0, wd_sum[9]};
    fold2  = {1'b0, fold1[2:0]} + {2'b00, fold1[4:3]};
    wd_mod = (fold2 >= WEEK_DAYS) ? (fold2 - WEEK_DAYS) : fold2;
    weekday_next = wd_mod[2:0] + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      date_valid    <= ok;
      year_value    <= ok ? full_year : 14'd0;
      month_value   <= ok ? mo_bin : 4'd0;
      day_value     <= ok ? dy_bin : 5'd0;
      hour_value    <= ok ? hr_bin : 5'd0;
      minute_value  <= ok ? mi_bin : 6'd0;
      second_value  <= ok ? se_bin : 6'd0;
      weekday_value <= ok ? weekday_next : 3'd0;
      daylight_out  <= ok ? daylight_q[0] : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_valid |-> year_value == 14'd0 && month_value == 4'd0 &&
      day_value == 5'd0 && hour_value == 5'd0 && minute_value == 6'd0 &&
      second_value == 6'd0 && weekday_value == 3'd0 && !daylight_out)
    else $error("invalid reading with nonzero fields");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid |-> weekday_value != 3'd0 && month_value != 4'd0 &&
      month_value <= MONTH_MAX && day_value != 5'd0 && year_value != 14'd0)
    else $error("valid reading with bad date fields");

  a_valid_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid |-> hour_value <= HOUR_MAX &&
      minute_value <= MINUTE_MAX && second_value <= SECOND_MAX)
    else $error("valid reading with time out of range");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> in_full)
    else $error("transfer lost in input stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    in_full && out_adv |=> out_valid)
    else $error("input stage did not reach result register");
`endif

endmodule
